>>> src/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants for the double bubble sorter
// payload structs, store sizing, ieee compare helper
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int MaxElements = 64;
    localparam int IdxW        = $clog2(MaxElements);
    localparam int CntW        = $clog2(MaxElements + 1);

    typedef struct packed {
        logic [63:0] element_bits;
        logic        final_element;
    } t_in_item;

    typedef struct packed {
        logic [63:0] sorted_bits;
        logic        end_of_block;
    } t_out_item;

    // ieee a > b on bit patterns, nan never greater
    function automatic logic ieee_gt(input logic [63:0] a, input logic [63:0] b);
        logic        a_nan;
        logic        b_nan;
        logic [63:0] ka;
        logic [63:0] kb;
        a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        ka    = a[63] ? ~a : {1'b1, a[62:0]};
        kb    = b[63] ? ~b : {1'b1, b[62:0]};
        if (a_nan || b_nan) begin
            return 1'b0;
        end
        if ((a[62:0] | b[62:0]) == 63'd0) begin
            return 1'b0;
        end
        return ka > kb;
    endfunction

endpackage

>>> src/bsd_cmp.sv
// ----------------------------------------------------------------------------
// bsd_cmp: shared compare unit
// registered ieee greater-than of two adjacent entries
// ----------------------------------------------------------------------------
module bsd_cmp
    import bsd_pkg::*;
(
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_gt
);
    logic r_gt;

    always_ff @(posedge i_clk) begin
        r_gt <= ieee_gt(i_a, i_b);
    end

    assign o_gt = r_gt;
endmodule

>>> src/bubble_sort_doubles.sv
// ----------------------------------------------------------------------------
// bubble_sort_doubles: block bubble sort of ieee doubles
// loads items into a 64 entry store, sorts in place, streams results out
// ----------------------------------------------------------------------------
// sequence: a non-final item is taken in S_LOAD; a final item with n loaded values
// starts n*(n-1)/2 compare steps, each through S_RDA, S_RDB, S_CMP and S_WRA, plus
// S_WRB when the pair swaps; then each output item passes S_ORD and S_OUT,
// held in S_OUT by any output stall; compare steps run one at a time, set by the single
// read/write port store and the one registered shared compare unit
// reset: synchronous active low, clears the sequencer and loaded count;
// store contents are left as they are
module bubble_sort_doubles
    import bsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);
    // sequencer codes
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;  // read left entry
    localparam logic [2:0] S_RDB  = 3'd2;  // read right entry
    localparam logic [2:0] S_CMP  = 3'd3;  // compare unit registers its result
    localparam logic [2:0] S_WRB  = 3'd4;  // second write of a swap
    localparam logic [2:0] S_ORD  = 3'd5;  // issue output read
    localparam logic [2:0] S_OUT  = 3'd6;  // hold output item
    localparam logic [2:0] S_WRA  = 3'd7;  // compare result lands, first write of a swap

    logic [2:0]       r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;     // loaded count
    logic [CntW-1:0]  r_lim, n_lim;     // compares left in this pass + k
    logic [IdxW-1:0]  r_k, n_k;
    logic [63:0]      r_a, r_b;         // latched operands
    logic [63:0]      r_rd;             // registered store read
    logic [63:0]      mem [MaxElements];

    // store port controls
    logic             we;
    logic [IdxW-1:0]  addr;
    logic [63:0]      wdata;
    logic             gt;
    logic             acc;
    logic             step_last;        // last compare of the pass

    assign acc       = i_valid && !o_stall;
    assign o_stall   = (r_state != S_LOAD);
    assign step_last = (CntW'(r_k) + 1'b1 >= r_lim);

    // single-port store, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        r_rd <= mem[addr];
    end

    bsd_cmp u_cmp (
        .i_clk (i_clk),
        .i_a   (r_a),
        .i_b   (r_rd),
        .o_gt  (gt)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lim   = r_lim;
        n_k     = r_k;
        we      = 1'b0;
        addr    = r_k;
        wdata   = r_b;
        unique case (r_state)
            S_LOAD: begin
                addr  = r_cnt[IdxW-1:0];
                wdata = i_data.element_bits;
                if (acc) begin
                    if (r_cnt < CntW'(MaxElements)) begin
                        we    = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (i_data.final_element) begin
                        n_k   = '0;
                        n_lim = (r_cnt < CntW'(MaxElements)) ? r_cnt : r_cnt - 1'b1;
                        // n_lim = last index of the pass
                        n_state = ((r_cnt < CntW'(MaxElements) ? r_cnt : r_cnt - 1'b1)
                                   == '0) ? S_ORD : S_RDA;
                    end
                end
            end
            S_RDA: begin
                addr    = r_k;
                n_state = S_RDB;
            end
            S_RDB: begin
                addr    = IdxW'(r_k + 1'b1);
                n_state = S_CMP;
            end
            S_CMP: begin
                // both operands present at the compare unit this cycle
                n_state = S_WRA;
            end
            S_WRA: begin
                // gt of entries k and k+1 valid now
                if (gt) begin
                    we      = 1'b1;
                    addr    = r_k;
                    wdata   = r_b;
                    n_state = S_WRB;
                end else if (step_last) begin
                    n_k     = '0;
                    n_lim   = r_lim - 1'b1;
                    n_state = (r_lim <= CntW'(1)) ? S_ORD : S_RDA;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RDA;
                end
            end
            S_WRB: begin
                we    = 1'b1;
                addr  = IdxW'(r_k + 1'b1);
                wdata = r_a;
                if (step_last) begin
                    n_k   = '0;
                    n_lim = r_lim - 1'b1;
                    n_state = (r_lim <= CntW'(1)) ? S_ORD : S_RDA;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RDA;
                end
            end
            S_ORD: begin
                addr    = r_k;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (CntW'(r_k) + 1'b1 == r_cnt) begin
                        n_cnt   = '0;
                        n_k     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // operand capture: left entry arrives in S_RDB, right entry in S_CMP
    always_ff @(posedge i_clk) begin
        if (r_state == S_RDB) begin
            r_a <= r_rd;
        end
        if (r_state == S_CMP) begin
            r_b <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_lim   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lim   <= n_lim;
            r_k     <= n_k;
        end
    end

    // output item read from the store straight into r_obits in S_ORD
    logic [63:0] r_obits;
    always_ff @(posedge i_clk) begin
        if (r_state == S_ORD) begin
            r_obits <= mem[r_k];
        end
    end

    assign o_valid             = (r_state == S_OUT);
    assign o_data.sorted_bits  = r_obits;
    assign o_data.end_of_block = (CntW'(r_k) + 1'b1 == r_cnt);

    // no new item taken while sorting or emitting
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !acc)
        else $error("item accepted while busy");

    // a stalled output holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_k)))
        else $error("output changed under stall");

    // loaded count never exceeds capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxElements))
        else $error("loaded count overflow");
endmodule
